// ===== src/ssrs_pkg.sv =====
package ssrs_pkg;

  // Field widths of the pixel coordinates, radii and colors.
  localparam int CoordW = 10;
  localparam int ColorW = 24;
  localparam int ChanW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  // Default subsample grid.
  localparam int DefSubRows = 50;
  localparam int DefSubCols = 50;

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegCentre    = 3'd0,
    RegInnerRad  = 3'd1,
    RegOuterRad  = 3'd2,
    RegCoreColor = 3'd3,
    RegRingOne   = 3'd4,
    RegRingTwo   = 3'd5,
    RegRingThree = 3'd6,
    RegOutside   = 3'd7
  } reg_idx_e;

  // Configuration as seen by the datapath: radius one is entry 0,
  // colors run from the core (entry 0) to the outside (entry 4).
  typedef struct packed {
    logic [CoordW-1:0]           centre;
    logic [3:0][CoordW-1:0]      radius;
    logic [4:0][ColorW-1:0]      color;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    centre: 10'd250,
    radius: {10'd200, 10'd150, 10'd100, 10'd50},
    color:  {24'hE97A7A, 24'h7FD7D4, 24'h857EBB, 24'hCA9DD7, 24'hFACBD3}
  };

  // Status of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/ssrs_queue.sv =====
module ssrs_queue import ssrs_pkg::*; #(
  parameter int WIDTH = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output q_status_t        status_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign data_o = mem_q[rd_ptr_q];

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/ssrs_front.sv =====
module ssrs_front import ssrs_pkg::*; #(
  parameter int SUB_ROWS = DefSubRows,
  parameter int SUB_COLS = DefSubCols,
  localparam int MagW = $clog2(4 * SUB_ROWS * SUB_COLS * (2 ** CoordW)),
  localparam int TW = MagW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] pixel_row_i,
  input  logic [CoordW-1:0] pixel_col_i,
  input  logic [CoordW-1:0] centre_i,
  input  q_status_t         q_status_i,
  output logic              q_push_o,
  output logic [2*TW-1:0]   q_data_o
);

  localparam logic signed [TW-1:0] Scale = TW'(4 * SUB_ROWS * SUB_COLS);
  localparam logic signed [TW-1:0] HalfY = TW'(2 * SUB_COLS);
  localparam logic signed [TW-1:0] HalfX = TW'(2 * SUB_ROWS);

  logic                     valid_q;
  logic signed [CoordW:0]   drow_q, dcol_q;
  logic signed [CoordW:0]   drow_d, dcol_d;
  logic signed [TW-1:0]     drow_ext, dcol_ext;
  logic signed [TW-1:0]     ty0, tx0;
  logic                     accept;

  // The stage holds its word while the queue is full.
  assign in_stall_o = valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = valid_q && !q_status_i.full;

  // Offsets from the centre, in whole pixels.
  assign drow_d = $signed({1'b0, pixel_row_i}) - $signed({1'b0, centre_i});
  assign dcol_d = $signed({1'b0, pixel_col_i}) - $signed({1'b0, centre_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (q_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drow_q <= drow_d;
      dcol_q <= dcol_d;
    end
  end

  // Scaled offsets of the first subsample in the pixel.
  assign drow_ext = TW'(drow_q);
  assign dcol_ext = TW'(dcol_q);
  assign ty0 = drow_ext * Scale + HalfY;
  assign tx0 = dcol_ext * Scale + HalfX;
  assign q_data_o = {ty0, tx0};

endmodule

// ===== src/ssrs_back.sv =====
module ssrs_back import ssrs_pkg::*; #(
  parameter int SUB_ROWS = DefSubRows,
  parameter int SUB_COLS = DefSubCols,
  localparam int MagW = $clog2(4 * SUB_ROWS * SUB_COLS * (2 ** CoordW)),
  localparam int TW = MagW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic [2*TW-1:0]  q_data_i,
  input  q_status_t        q_status_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  localparam int Count = SUB_ROWS * SUB_COLS;
  localparam int SqW = 2 * MagW;
  localparam int DistW = SqW + 1;
  localparam int SumW = $clog2(255 * Count + 1);
  // Reciprocal of the subsample count, exact for every sum below 2**SumW.
  localparam int RecipShift = SumW + $clog2(Count);
  localparam int RecipW = SumW + 1;
  localparam int ProdW = SumW + RecipW;
  localparam longint RecipL =
    ((longint'(1) << RecipShift) + longint'(Count) - longint'(1)) / longint'(Count);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);
  localparam int RowW = (SUB_ROWS > 1) ? $clog2(SUB_ROWS) : 1;
  localparam int ColW = (SUB_COLS > 1) ? $clog2(SUB_COLS) : 1;
  localparam logic [MagW-1:0] Scale = MagW'(4 * SUB_ROWS * SUB_COLS);
  localparam logic signed [TW-1:0] StepY = TW'(4 * SUB_COLS);
  localparam logic signed [TW-1:0] StepX = TW'(4 * SUB_ROWS);

  typedef enum logic [2:0] {
    StIdle, StSweep, StDrain, StDivide, StHold
  } state_e;

  typedef enum logic [2:0] {
    RingCore, RingOne, RingTwo, RingThree, RingOutside
  } ring_e;

  state_e                 state_q;
  logic [RowW-1:0]        row_q;
  logic [ColW-1:0]        col_q;
  logic signed [TW-1:0]   ty_q, tx_q, tx_base_q;
  logic [SumW-1:0]        sum_q [3];
  logic [SumW-1:0]        num_q [3];
  logic [ProdW-1:0]       prod [3];
  logic                   out_valid_q;
  logic [ChanW-1:0]       red_q, green_q, blue_q;

  logic                   issue;
  logic                   row_last, col_last, out_free;
  logic [MagW-1:0]        mag_y, mag_x;
  logic [MagW-1:0]        s_q [4];
  logic [SqW-1:0]         lim_q [4];
  logic [SqW-1:0]         sqy_q, sqx_q;
  logic                   v1_q, v2_q;
  logic [DistW-1:0]       dist_sum;
  ring_e                  ring_d, ring_q;
  logic [ColorW-1:0]      pick;

  // Squared radius limits follow the configuration continuously.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      s_q[k]   <= MagW'(cfg_i.radius[k]) * Scale;
      lim_q[k] <= SqW'(s_q[k]) * SqW'(s_q[k]);
    end
  end

  assign issue    = (state_q == StSweep);
  assign row_last = (row_q == RowW'(SUB_ROWS - 1));
  assign col_last = (col_q == ColW'(SUB_COLS - 1));
  assign q_pop_o  = (state_q == StIdle) && !q_status_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;

  // Stage one: magnitudes of the scaled offsets, squared.
  assign mag_y = ty_q[TW-1] ? MagW'(-ty_q) : MagW'(ty_q);
  assign mag_x = tx_q[TW-1] ? MagW'(-tx_q) : MagW'(tx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqy_q  <= SqW'(mag_y) * SqW'(mag_y);
    sqx_q  <= SqW'(mag_x) * SqW'(mag_x);
    ring_q <= ring_d;
  end

  // Stage two: the innermost disc that holds the subsample wins.
  assign dist_sum = DistW'(sqy_q) + DistW'(sqx_q);

  always_comb begin
    if (dist_sum <= DistW'(lim_q[0])) begin
      ring_d = RingCore;
    end else if (dist_sum <= DistW'(lim_q[1])) begin
      ring_d = RingOne;
    end else if (dist_sum <= DistW'(lim_q[2])) begin
      ring_d = RingTwo;
    end else if (dist_sum <= DistW'(lim_q[3])) begin
      ring_d = RingThree;
    end else begin
      ring_d = RingOutside;
    end
  end

  always_comb begin
    case (ring_q)
      RingCore:    pick = cfg_i.color[0];
      RingOne:     pick = cfg_i.color[1];
      RingTwo:     pick = cfg_i.color[2];
      RingThree:   pick = cfg_i.color[3];
      default:     pick = cfg_i.color[4];
    endcase
  end

  // Division by the subsample count as a multiplication by its reciprocal.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = ProdW'(num_q[ch]) * ProdW'(Recip);
    end
  end

  // Sequencer: subsample sweep, accumulation, division and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      col_q       <= '0;
      ty_q        <= '0;
      tx_q        <= '0;
      tx_base_q   <= '0;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= '0;
        num_q[ch] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != StHold)) begin
        out_valid_q <= 1'b0;
      end

      if (v2_q) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= sum_q[ch] + SumW'(pick[ColorW-1-ChanW*ch -: ChanW]);
        end
      end else if (q_pop_o) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= '0;
        end
      end

      case (state_q)
        StIdle: begin
          if (q_pop_o) begin
            ty_q      <= q_data_i[2*TW-1:TW];
            tx_q      <= q_data_i[TW-1:0];
            tx_base_q <= q_data_i[TW-1:0];
            row_q     <= '0;
            col_q     <= '0;
            state_q   <= StSweep;
          end
        end
        StSweep: begin
          if (col_last) begin
            col_q <= '0;
            tx_q  <= tx_base_q;
            ty_q  <= ty_q + StepY;
            row_q <= row_q + 1'b1;
            if (row_last) begin
              state_q <= StDrain;
            end
          end else begin
            col_q <= col_q + 1'b1;
            tx_q  <= tx_q + StepX;
          end
        end
        StDrain: begin
          if (!v1_q && !v2_q) begin
            for (int ch = 0; ch < 3; ch++) begin
              num_q[ch] <= sum_q[ch];
            end
            state_q <= StDivide;
          end
        end
        StDivide: begin
          for (int ch = 0; ch < 3; ch++) begin
            num_q[ch] <= SumW'(prod[ch] >> RecipShift);
          end
          state_q <= StHold;
        end
        StHold: begin
          if (out_free) begin
            red_q       <= num_q[0][ChanW-1:0];
            green_q     <= num_q[1][ChanW-1:0];
            blue_q      <= num_q[2][ChanW-1:0];
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

// ===== src/supersampled_ring_shader_unit.sv =====
// Antialiased shading of one pixel over four concentric rings.
// Input channel: in_valid_i / in_stall_o with pixel_row_i and pixel_col_i; a
// word is taken when valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i with red_o, green_o and blue_o, one word per pixel.
// Configuration: cfg_valid_i / cfg_ready_o write cfg_data_i into register
// cfg_index_i; ready is always high. Write only while no pixel is in flight.
// The front registers the pixel's offsets from the centre and places the
// scaled starting offsets in a two-entry queue, so up to three pixels can
// wait while the back works. The back evaluates one subsample per cycle and
// then divides the channel sums by a reciprocal multiplication.
// Throughput is set by the single subsample evaluator: the back takes a new
// pixel only once the last one has been swept, drained, divided and handed
// to the output register. An accepted input passes the front register, the
// queue, and the back's sweep, drain, divide and hold states to the output.
// A stalled result holds; the back finishes the next pixel and waits for the
// output register to free. Reset empties the pipeline and queue and restores
// the default centre, radii and colors.
module supersampled_ring_shader_unit import ssrs_pkg::*; #(
  parameter int SUB_ROWS = DefSubRows,
  parameter int SUB_COLS = DefSubCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CoordW-1:0]   pixel_row_i,
  input  logic [CoordW-1:0]   pixel_col_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChanW-1:0]    red_o,
  output logic [ChanW-1:0]    green_o,
  output logic [ChanW-1:0]    blue_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int MagW = $clog2(4 * SUB_ROWS * SUB_COLS * (2 ** CoordW));
  localparam int TW = MagW + 1;

  cfg_t            cfg_q, cfg_d;
  q_status_t       q_status;
  logic            q_push, q_pop;
  logic [2*TW-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration register file.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        RegCentre:    cfg_d.centre = cfg_data_i[CoordW-1:0];
        RegInnerRad: begin
          cfg_d.radius[0] = cfg_data_i[CoordW-1:0];
          cfg_d.radius[1] = cfg_data_i[2*CoordW-1:CoordW];
        end
        RegOuterRad: begin
          cfg_d.radius[2] = cfg_data_i[CoordW-1:0];
          cfg_d.radius[3] = cfg_data_i[2*CoordW-1:CoordW];
        end
        RegCoreColor: cfg_d.color[0] = cfg_data_i[ColorW-1:0];
        RegRingOne:   cfg_d.color[1] = cfg_data_i[ColorW-1:0];
        RegRingTwo:   cfg_d.color[2] = cfg_data_i[ColorW-1:0];
        RegRingThree: cfg_d.color[3] = cfg_data_i[ColorW-1:0];
        RegOutside:   cfg_d.color[4] = cfg_data_i[ColorW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssrs_front #(
    .SUB_ROWS (SUB_ROWS),
    .SUB_COLS (SUB_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .centre_i    (cfg_q.centre),
    .q_status_i  (q_status),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  ssrs_queue #(
    .WIDTH (2 * TW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  ssrs_back #(
    .SUB_ROWS (SUB_ROWS),
    .SUB_COLS (SUB_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_data_i    (q_rdata),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

// ===== verif/ssrs_checker.sv =====
module ssrs_checker import ssrs_pkg::*; #(
  parameter int SUB_ROWS = DefSubRows,
  parameter int SUB_COLS = DefSubCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CoordW-1:0]   pixel_row_i,
  input  logic [CoordW-1:0]   pixel_col_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [ChanW-1:0]    red_i,
  input  logic [ChanW-1:0]    green_i,
  input  logic [ChanW-1:0]    blue_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Mirror of the shading registers, updated on every accepted config word.
  cfg_t shade_cfg;
  rgb_t expected_rgb_q[$];
  int   mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  // Averages the colors of all subsamples of one pixel. Distances are kept
  // as exact integers scaled by the subsample grid, so no rounding occurs.
  function automatic rgb_t shade_pixel(input logic [CoordW-1:0] row,
                                       input logic [CoordW-1:0] col,
                                       input cfg_t cfg);
    longint ctr, s, dy, dx, ty, tx, dist_sq;
    longint lim[4];
    int unsigned sum_r, sum_g, sum_b, cnt;
    logic [ColorW-1:0] c;
    rgb_t res;
    int k, m, n;
    ctr = longint'(cfg.centre);
    for (k = 0; k < 4; k++) begin
      s = longint'(4 * SUB_ROWS * SUB_COLS) * longint'(cfg.radius[k]);
      lim[k] = s * s;
    end
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (m = 0; m < SUB_ROWS; m++) begin
      dy = longint'(2 * SUB_ROWS) * (longint'(row) - ctr) + longint'(2 * m + 1);
      ty = longint'(2 * SUB_COLS) * dy;
      for (n = 0; n < SUB_COLS; n++) begin
        dx = longint'(2 * SUB_COLS) * (longint'(col) - ctr) + longint'(2 * n + 1);
        tx = longint'(2 * SUB_ROWS) * dx;
        dist_sq = ty * ty + tx * tx;
        // Discs are tried from radius one outward; the first hit wins.
        if (dist_sq <= lim[0]) begin
          c = cfg.color[0];
        end else if (dist_sq <= lim[1]) begin
          c = cfg.color[1];
        end else if (dist_sq <= lim[2]) begin
          c = cfg.color[2];
        end else if (dist_sq <= lim[3]) begin
          c = cfg.color[3];
        end else begin
          c = cfg.color[4];
        end
        sum_r += c[23:16];
        sum_g += c[15:8];
        sum_b += c[7:0];
      end
    end
    cnt = SUB_ROWS * SUB_COLS;
    res.red   = ChanW'(sum_r / cnt);
    res.green = ChanW'(sum_g / cnt);
    res.blue  = ChanW'(sum_b / cnt);
    return res;
  endfunction

  task automatic check_chan(input string name, input logic [ChanW-1:0] want,
                            input logic [ChanW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  // Watch all three channels at the clock edge where words are accepted.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    rgb_t want;
    if (!rst_ni) begin
      shade_cfg.centre = 10'd250;
      shade_cfg.radius = {10'd200, 10'd150, 10'd100, 10'd50};
      shade_cfg.color  = {24'hE97A7A, 24'h7FD7D4, 24'h857EBB, 24'hCA9DD7, 24'hFACBD3};
      expected_rgb_q.delete();
      pending_o <= 0;
    end else begin
      // Register writes; bits above a register's width are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          RegCentre: begin
            shade_cfg.centre = cfg_data_i[9:0];
          end
          RegInnerRad: begin
            shade_cfg.radius[0] = cfg_data_i[9:0];
            shade_cfg.radius[1] = cfg_data_i[19:10];
          end
          RegOuterRad: begin
            shade_cfg.radius[2] = cfg_data_i[9:0];
            shade_cfg.radius[3] = cfg_data_i[19:10];
          end
          RegCoreColor: shade_cfg.color[0] = cfg_data_i;
          RegRingOne:   shade_cfg.color[1] = cfg_data_i;
          RegRingTwo:   shade_cfg.color[2] = cfg_data_i;
          RegRingThree: shade_cfg.color[3] = cfg_data_i;
          RegOutside:   shade_cfg.color[4] = cfg_data_i;
          default: ;
        endcase
      end
      // Each result word is matched against the oldest shaded pixel.
      if (out_valid_i && !out_stall_i) begin
        if (expected_rgb_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                   $time, red_i, green_i, blue_i);
          mismatch_total++;
        end else begin
          want = expected_rgb_q.pop_front();
          check_chan("red", want.red, red_i);
          check_chan("green", want.green, green_i);
          check_chan("blue", want.blue, blue_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rgb_q.push_back(shade_pixel(pixel_row_i, pixel_col_i, shade_cfg));
      end
      pending_o <= expected_rgb_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import ssrs_pkg::*;

  localparam int SubRows = DefSubRows;
  localparam int SubCols = DefSubCols;
  localparam int MaxCoord = (1 << CoordW) - 1;
  localparam int PixelCycles = SubRows * SubCols + 100;
  // Long enough for the output, the back end and the queue to fill up.
  localparam int HoldCycles = 8 * PixelCycles;
  localparam longint TimeoutNs = 64'd4 * 300 * PixelCycles * 10;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CoordW-1:0]   pixel_row = '0;
  logic [CoordW-1:0]   pixel_col = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ChanW-1:0]    red, green, blue;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  mismatches;
  int                  pending;

  // Stimulus-side view of the geometry, used only to aim pixels at the rings.
  int cur_centre = 250;
  int cur_rad[4] = '{50, 100, 150, 200};
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  supersampled_ring_shader_unit #(
    .SUB_ROWS(SubRows),
    .SUB_COLS(SubCols)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .pixel_row_i(pixel_row),
    .pixel_col_i(pixel_col),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  ssrs_checker #(
    .SUB_ROWS(SubRows),
    .SUB_COLS(SubCols)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .pixel_row_i (pixel_row),
    .pixel_col_i (pixel_col),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  function automatic logic [CoordW-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > MaxCoord) return CoordW'(MaxCoord);
    return v[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] pick_radius();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CoordW'(MaxCoord);
      2: return CoordW'($urandom_range(0, MaxCoord));
      default: return CoordW'($urandom_range(1, 300));
    endcase
  endfunction

  // Random register contents, with the extremes favored; unused upper bits
  // stay random so that masking is exercised.
  function automatic logic [CfgDataW-1:0] pick_reg_value(input reg_idx_e idx);
    logic [CfgDataW-1:0] v;
    int sel;
    v = CfgDataW'($urandom);
    sel = $urandom_range(0, 3);
    case (idx)
      RegCentre: begin
        if (sel == 0) v[9:0] = '0;
        else if (sel == 1) v[9:0] = CoordW'(MaxCoord);
      end
      RegInnerRad, RegOuterRad: begin
        v[9:0] = pick_radius();
        v[19:10] = pick_radius();
      end
      default: begin
        if (sel == 0) v = '0;
        else if (sel == 1) v = '1;
      end
    endcase
    return v;
  endfunction

  // Writes one config word and leaves valid high for a following write.
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    case (idx)
      RegCentre: cur_centre = data[9:0];
      RegInnerRad: begin
        cur_rad[0] = data[9:0];
        cur_rad[1] = data[19:10];
      end
      RegOuterRad: begin
        cur_rad[2] = data[9:0];
        cur_rad[3] = data[19:10];
      end
      default: ;
    endcase
  endtask

  // Offers one pixel word, after an occasional idle burst.
  task automatic shade(input logic [CoordW-1:0] row, input logic [CoordW-1:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    pixel_row <= row;
    pixel_col <= col;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Drains the block so that registers may be written.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Pixels near a ring edge, near the centre, or anywhere on the grid.
  task automatic random_pixel(output logic [CoordW-1:0] row,
                              output logic [CoordW-1:0] col);
    int k, sgn, d, span;
    int sel;
    sel = $urandom_range(0, 9);
    k = $urandom_range(0, 3);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    if (sel < 2) begin
      row = clamp_coord(cur_centre + sgn * cur_rad[k] + int'($urandom_range(0, 2)) - 1);
      col = clamp_coord(cur_centre + int'($urandom_range(0, 4)) - 2);
    end else if (sel < 4) begin
      d = cur_rad[k] * 707 / 1000;
      row = clamp_coord(cur_centre + sgn * d + int'($urandom_range(0, 2)) - 1);
      sgn = $urandom_range(0, 1) ? 1 : -1;
      col = clamp_coord(cur_centre + sgn * d + int'($urandom_range(0, 2)) - 1);
    end else if (sel < 7) begin
      span = 4;
      for (k = 0; k < 4; k++) begin
        if (cur_rad[k] + 4 > span) span = cur_rad[k] + 4;
      end
      row = clamp_coord(cur_centre + int'($urandom_range(0, 2 * span)) - span);
      col = clamp_coord(cur_centre + int'($urandom_range(0, 2 * span)) - span);
    end else begin
      row = CoordW'($urandom_range(0, MaxCoord));
      col = CoordW'($urandom_range(0, MaxCoord));
    end
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 4) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [CoordW-1:0] row, col;
    int p, i, r;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values: centre, corners and ring edges.
    shade(10'd250, 10'd250);
    shade(10'd0, 10'd0);
    shade(10'd1023, 10'd1023);
    shade(10'd0, 10'd1023);
    shade(10'd1023, 10'd0);
    shade(10'd299, 10'd250);
    shade(10'd250, 10'd449);
    shade(10'd391, 10'd391);
    drain();

    // Centre at zero, an empty core disc, and rings out of order so that
    // ring two is hidden behind ring one.
    write_reg(RegCentre, 24'hFFFC00);
    write_reg(RegInnerRad, {4'hF, 10'd300, 10'd0});
    write_reg(RegOuterRad, {4'hA, 10'd1023, 10'd100});
    write_reg(RegCoreColor, 24'hFFFFFF);
    write_reg(RegRingOne, 24'h000000);
    write_reg(RegRingTwo, 24'hFF00FF);
    write_reg(RegRingThree, 24'h00FF00);
    write_reg(RegOutside, 24'h5A3C96);
    cfg_valid <= 1'b0;
    shade(10'd0, 10'd0);
    shade(10'd70, 10'd70);
    shade(10'd212, 10'd212);
    shade(10'd723, 10'd723);
    shade(10'd1023, 10'd1023);
    shade(10'd1023, 10'd0);
    drain();

    // Largest centre and all radii at their maximum.
    write_reg(RegCentre, 24'hFFFFFF);
    write_reg(RegInnerRad, 24'hFFFFFF);
    write_reg(RegOuterRad, 24'h0FFFFF);
    cfg_valid <= 1'b0;
    shade(10'd0, 10'd0);
    shade(10'd1023, 10'd1023);
    shade(10'd0, 10'd1023);
    shade(10'd1, 10'd300);
    drain();

    // Random phases, each with a fresh mix of register values.
    for (p = 0; p < RandPhases; p++) begin
      for (r = 0; r < 8; r++) begin
        if ($urandom_range(0, 1)) write_reg(reg_idx_e'(r), pick_reg_value(reg_idx_e'(r)));
      end
      cfg_valid <= 1'b0;
      if (p == RandPhases - 1) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      // Back-pressure: the result side holds off while pixels keep coming.
      if (p == 1) begin
        idle_on = 1'b0;
        hold_req = 1'b1;
      end
      for (i = 0; i < PhaseItems; i++) begin
        random_pixel(row, col);
        shade(row, col);
      end
      drain();
    end

    repeat (PixelCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
